[src/kmce_pkg.sv]
package kmce_pkg;

  localparam int CNT_W      = 7;
  localparam int DATA_W     = 32;
  localparam int OP_W       = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 1;
  localparam int FRAC_W     = 16;
  localparam int DIVN_W     = DATA_W + CNT_W;
  localparam int DIVD_W     = 2 * CNT_W;

  localparam logic [OP_W-1:0] OP_LOAD    = 2'd0;
  localparam logic [OP_W-1:0] OP_COMPUTE = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY   = 2'd2;
  localparam logic [OP_W-1:0] OP_CLEAR   = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_REVERSE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEFT    = 1'b1;

  localparam logic [DATA_W-1:0] Q31_ONE = 32'h8000_0000;
  localparam logic [DATA_W-1:0] VAR_SAT = 32'hFFFF_FFFF;

  typedef struct packed {
    logic load;
    logic clear;
    logic comp_start;
    logic fetch_take;
    logic count_issue;
    logic arith;
    logic div_surv;
    logic surv_take;
    logic var_take;
    logic emit;
    logic q_start;
    logic q_chk0;
    logic q_chkm;
    logic q_scan;
    logic q_emit;
  } kmce_cmd_t;

  typedef struct packed {
    logic has_samples;
    logic curve_empty;
    logic grp_end;
    logic k_last;
    logic i_last;
    logic act;
    logic ok;
    logic div_done;
    logic slot_free;
    logic q_below;
    logic q_beyond;
    logic q_cont;
  } kmce_sts_t;

endpackage

[src/kmce_ifs.sv]
interface kmce_in_if;
  import kmce_pkg::*;
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [DATA_W-1:0] sample_time;
  logic              event_flag;
  logic [DATA_W-1:0] entry_time;
  logic [DATA_W-1:0] query_time;
  modport source (output valid, op, sample_time, event_flag, entry_time, query_time,
                  input ready);
  modport sink (input valid, op, sample_time, event_flag, entry_time, query_time,
                output ready);
endinterface

interface kmce_out_if;
  import kmce_pkg::*;
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] time_value;
  logic [DATA_W-1:0] survival;
  logic [DATA_W-1:0] var_hazard;
  logic [CNT_W-1:0]  at_risk;
  logic              last;
  logic              overflow;
  modport source (output valid, time_value, survival, var_hazard, at_risk, last, overflow,
                  input ready);
  modport sink (input valid, time_value, survival, var_hazard, at_risk, last, overflow,
                output ready);
endinterface

[src/kmce_div.sv]
module kmce_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [kmce_pkg::DIVN_W-1:0] dividend,
  input  logic [kmce_pkg::DIVD_W-1:0] divisor,
  output logic [kmce_pkg::DIVN_W-1:0] quotient,
  output logic                        done
);
  import kmce_pkg::*;

  localparam int CNT_DW = $clog2(DIVN_W);

  logic [DIVN_W-1:0] quo_r;
  logic [DIVD_W-1:0] rem_r;
  logic [DIVD_W-1:0] den_r;
  logic [CNT_DW-1:0] cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [DIVD_W:0]   trial;
  logic              ge;

  // one quotient bit a cycle, restoring
  assign trial = {rem_r, quo_r[DIVN_W-1]};
  assign ge    = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_DW'(DIVN_W - 1);
        quo_r  <= dividend;
        rem_r  <= '0;
        den_r  <= divisor;
      end else if (busy_r) begin
        rem_r <= ge ? DIVD_W'(trial - {1'b0, den_r}) : DIVD_W'(trial);
        quo_r <= {quo_r[DIVN_W-2:0], ge};
        cnt_r <= cnt_r - CNT_DW'(1);
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign quotient = quo_r;
  assign done     = done_r;

endmodule

[src/kmce_ctrl.sv]
module kmce_ctrl (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic [kmce_pkg::OP_W-1:0] in_op,
  output logic                    in_ready,
  input  kmce_pkg::kmce_sts_t     sts,
  output kmce_pkg::kmce_cmd_t     cmd
);
  import kmce_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_FETCH = 4'd1;
  localparam logic [3:0] S_FWAIT = 4'd2;
  localparam logic [3:0] S_COUNT = 4'd3;
  localparam logic [3:0] S_CLAST = 4'd4;
  localparam logic [3:0] S_ARITH = 4'd5;
  localparam logic [3:0] S_DIVS  = 4'd6;
  localparam logic [3:0] S_DIV1  = 4'd7;
  localparam logic [3:0] S_DIV2  = 4'd8;
  localparam logic [3:0] S_WRITE = 4'd9;
  localparam logic [3:0] S_QCHK0 = 4'd10;
  localparam logic [3:0] S_QCHKM = 4'd11;
  localparam logic [3:0] S_QSCAN = 4'd12;
  localparam logic [3:0] S_QOUT  = 4'd13;

  logic [3:0] state_r;
  logic [3:0] state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    in_ready  = (state_r == S_IDLE);
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          unique case (in_op)
            OP_LOAD:  cmd.load = 1'b1;
            OP_CLEAR: cmd.clear = 1'b1;
            OP_COMPUTE: begin
              cmd.comp_start = 1'b1;
              if (sts.has_samples) state_nxt = S_FETCH;
            end
            OP_QUERY: begin
              cmd.q_start = 1'b1;
              state_nxt   = sts.curve_empty ? S_QOUT : S_QCHK0;
            end
            default: ;
          endcase
        end
      end
      S_FETCH: state_nxt = S_FWAIT;
      S_FWAIT: begin
        cmd.fetch_take = 1'b1;
        state_nxt      = sts.grp_end ? S_COUNT : S_FETCH;
      end
      S_COUNT: begin
        cmd.count_issue = 1'b1;
        if (sts.k_last) state_nxt = S_CLAST;
      end
      S_CLAST: state_nxt = S_ARITH;
      S_ARITH: begin
        cmd.arith = 1'b1;
        state_nxt = (sts.act && sts.ok) ? S_DIVS : S_WRITE;
      end
      S_DIVS: begin
        cmd.div_surv = 1'b1;
        state_nxt    = S_DIV1;
      end
      S_DIV1: begin
        if (sts.div_done) begin
          cmd.surv_take = 1'b1;
          state_nxt     = S_DIV2;
        end
      end
      S_DIV2: begin
        if (sts.div_done) begin
          cmd.var_take = 1'b1;
          state_nxt    = S_WRITE;
        end
      end
      S_WRITE: begin
        if (sts.slot_free) begin
          cmd.emit  = 1'b1;
          state_nxt = sts.i_last ? S_IDLE : S_FETCH;
        end
      end
      S_QCHK0: begin
        cmd.q_chk0 = 1'b1;
        state_nxt  = sts.q_below ? S_QOUT : S_QCHKM;
      end
      S_QCHKM: begin
        cmd.q_chkm = 1'b1;
        state_nxt  = sts.q_beyond ? S_QOUT : S_QSCAN;
      end
      S_QSCAN: begin
        cmd.q_scan = 1'b1;
        state_nxt  = sts.q_cont ? S_QSCAN : S_QOUT;
      end
      S_QOUT: begin
        if (sts.slot_free) begin
          cmd.q_emit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

[src/kmce_dp.sv]
module kmce_dp #(
  parameter int MAX_SAMPLES = 64,
  parameter int TIME_BITS   = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  kmce_pkg::kmce_cmd_t             cmd,
  output kmce_pkg::kmce_sts_t             sts,
  input  logic                            cfg_we,
  input  logic [kmce_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [kmce_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic [kmce_pkg::DATA_W-1:0]     in_sample_time,
  input  logic                            in_event_flag,
  input  logic [kmce_pkg::DATA_W-1:0]     in_entry_time,
  input  logic [kmce_pkg::DATA_W-1:0]     in_query_time,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [kmce_pkg::DATA_W-1:0]     out_time_value,
  output logic [kmce_pkg::DATA_W-1:0]     out_survival,
  output logic [kmce_pkg::DATA_W-1:0]     out_var_hazard,
  output logic [kmce_pkg::CNT_W-1:0]      out_at_risk,
  output logic                            out_last,
  output logic                            out_overflow
);
  import kmce_pkg::*;

  localparam int TW = TIME_BITS;
  localparam int IW = $clog2(MAX_SAMPLES);
  localparam int SW = 2 * TW + 1;
  localparam int CW = TW + 2 * DATA_W + CNT_W;
  localparam int C_VAR  = CNT_W;
  localparam int C_SURV = CNT_W + DATA_W;
  localparam int C_TIME = CNT_W + 2 * DATA_W;

  // sample store: {time, event, entry}
  logic [SW-1:0] smem [MAX_SAMPLES];
  logic [SW-1:0] rda_r, rdb_r;
  logic [IW-1:0] addr_a, addr_b;
  // curve store: {time, survival, variance, at risk}
  logic [CW-1:0] cmem [MAX_SAMPLES];
  logic [CW-1:0] rdc_r, prev_r, cword;
  logic [IW-1:0] addr_c;

  logic [CNT_W-1:0] count_r, curve_len_r, i_r, k_r, s_r, ev_r, ls_r, nr_r, qa_r;
  logic             ovf_r, rev_r, left_r, cnt_v_r;
  logic [TW-1:0]    t_cur_r, qt_r;
  logic [DATA_W-1:0] surv_r, var_r, res_s_r, res_v_r;
  logic [CNT_W-1:0] res_ar_r, q7_r, d_r;
  logic [DIVN_W-1:0] prod_r;
  logic [DIVD_W-1:0] den_r;

  logic              out_valid_r, out_last_r, out_ovf_r;
  logic [DATA_W-1:0] out_time_r, out_surv_r, out_var_r;
  logic [CNT_W-1:0]  out_ar_r;

  logic              full, slot_free;
  logic [TW-1:0]     ta, tb, ea, tc;
  logic [CNT_W-1:0]  m, d, a;
  logic [CNT_W:0]    q_s;
  logic              pick_prev, div_start, div_done;
  logic [DIVN_W-1:0] div_quo, div_num;
  logic [DIVD_W-1:0] div_den;
  logic [DATA_W:0]   var_sum;

  assign ta = rda_r[SW-1:TW+1];
  assign ea = rda_r[TW-1:0];
  assign tb = rdb_r[SW-1:TW+1];
  assign tc = rdc_r[CW-1:C_TIME];
  assign m  = curve_len_r - CNT_W'(1);

  assign full      = (count_r == CNT_W'(MAX_SAMPLES));
  assign slot_free = !out_valid_r || out_ready;

  assign addr_a = cmd.count_issue ? k_r[IW-1:0] : i_r[IW-1:0];
  assign addr_b = i_r[IW-1:0] + IW'(1);
  assign addr_c = cmd.q_chk0 ? m[IW-1:0] : (cmd.q_scan ? qa_r[IW-1:0] + IW'(1) : '0);

  // event or loss count and denominator for the active mode
  assign d   = rev_r ? ls_r : ev_r;
  assign q_s = rev_r ? ({1'b0, nr_r} - {1'b0, ev_r}) : {1'b0, nr_r};
  assign a   = CNT_W'(q_s - {1'b0, d});

  assign cword     = {t_cur_r, surv_r, var_r, nr_r};
  assign pick_prev = (left_r ? (tc == qt_r) : (qt_r < tc)) && (qa_r != '0);

  assign div_start = cmd.div_surv || cmd.surv_take;
  assign div_num   = cmd.surv_take ? DIVN_W'({d_r, {FRAC_W{1'b0}}}) : prod_r;
  assign div_den   = cmd.surv_take ? den_r : DIVD_W'(q7_r);
  assign var_sum   = {1'b0, var_r} + {1'b0, div_quo[DATA_W-1:0]};

  kmce_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (div_den),
    .quotient (div_quo),
    .done     (div_done)
  );

  always_comb begin
    sts.has_samples = (count_r != '0);
    sts.curve_empty = (curve_len_r == '0);
    sts.grp_end     = (i_r == count_r - CNT_W'(1)) || (tb != ta);
    sts.k_last      = (k_r == count_r - CNT_W'(1));
    sts.i_last      = (i_r == count_r - CNT_W'(1));
    sts.act         = (d != '0) && (nr_r != '0);
    sts.ok          = $signed(q_s) > $signed({1'b0, d});
    sts.div_done    = div_done;
    sts.slot_free   = slot_free;
    sts.q_below     = left_r ? (qt_r <= tc) : (qt_r < tc);
    sts.q_beyond    = left_r ? (qt_r > tc) : (qt_r >= tc);
    sts.q_cont      = (qa_r < m) && (tc < qt_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.load && !full)
      smem[count_r[IW-1:0]] <= {TW'(in_sample_time), in_event_flag, TW'(in_entry_time)};
    rda_r <= smem[addr_a];
    rdb_r <= smem[addr_b];
    if (cmd.emit) cmem[s_r[IW-1:0]] <= cword;
    rdc_r <= cmem[addr_c];
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      curve_len_r <= '0;
      ovf_r       <= 1'b0;
      rev_r       <= 1'b0;
      left_r      <= 1'b0;
      cnt_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_v_r <= cmd.count_issue;
      if (cfg_we && cfg_idx == CFG_REVERSE) rev_r <= cfg_data[0];
      if (cfg_we && cfg_idx == CFG_LEFT)    left_r <= cfg_data[0];
      if (cmd.load) begin
        if (full) ovf_r <= 1'b1;
        else      count_r <= count_r + CNT_W'(1);
      end
      if (cmd.clear) begin
        count_r     <= '0;
        curve_len_r <= '0;
        ovf_r       <= 1'b0;
      end
      if (cmd.comp_start) curve_len_r <= '0;
      if (cmd.emit && sts.i_last) curve_len_r <= s_r + CNT_W'(1);
      if (cmd.emit || cmd.q_emit) out_valid_r <= 1'b1;
      else if (out_ready)         out_valid_r <= 1'b0;
    end
  end

  // curve build and query datapath
  always_ff @(posedge clk) begin
    if (cmd.comp_start) begin
      i_r    <= '0;
      s_r    <= '0;
      ev_r   <= '0;
      ls_r   <= '0;
      surv_r <= Q31_ONE;
      var_r  <= '0;
    end
    if (cmd.fetch_take) begin
      ev_r    <= ev_r + CNT_W'(rda_r[TW]);
      ls_r    <= ls_r + CNT_W'(!rda_r[TW]);
      t_cur_r <= ta;
      if (sts.grp_end) begin
        k_r  <= '0;
        nr_r <= '0;
      end else begin
        i_r <= i_r + CNT_W'(1);
      end
    end
    if (cmd.count_issue) k_r <= k_r + CNT_W'(1);
    if (cnt_v_r && ea <= t_cur_r && t_cur_r <= ta) nr_r <= nr_r + CNT_W'(1);
    if (cmd.arith) begin
      prod_r <= DIVN_W'(surv_r * a);
      den_r  <= DIVD_W'(q_s[CNT_W-1:0] * a);
      q7_r   <= q_s[CNT_W-1:0];
      d_r    <= d;
      if (sts.act && !sts.ok) begin
        surv_r <= '0;
        var_r  <= VAR_SAT;
      end
    end
    if (cmd.surv_take) surv_r <= div_quo[DATA_W-1:0];
    if (cmd.var_take)  var_r <= var_sum[DATA_W] ? VAR_SAT : var_sum[DATA_W-1:0];
    if (cmd.emit) begin
      s_r  <= s_r + CNT_W'(1);
      ev_r <= '0;
      ls_r <= '0;
      if (!sts.i_last) i_r <= i_r + CNT_W'(1);
      out_time_r <= DATA_W'(t_cur_r);
      out_surv_r <= surv_r;
      out_var_r  <= var_r;
      out_ar_r   <= nr_r;
      out_last_r <= sts.i_last;
      out_ovf_r  <= ovf_r;
    end
    if (cmd.q_start) begin
      qt_r     <= TW'(in_query_time);
      res_s_r  <= Q31_ONE;
      res_v_r  <= '0;
      res_ar_r <= '0;
    end
    if (cmd.q_chk0 && sts.q_below) res_ar_r <= rdc_r[CNT_W-1:0];
    if (cmd.q_chkm) begin
      qa_r <= '0;
      if (sts.q_beyond) begin
        res_s_r  <= rdc_r[C_TIME-1:C_SURV];
        res_v_r  <= rdc_r[C_SURV-1:C_VAR];
        res_ar_r <= rdc_r[CNT_W-1:0];
      end
    end
    if (cmd.q_scan) begin
      if (sts.q_cont) begin
        prev_r <= rdc_r;
        qa_r   <= qa_r + CNT_W'(1);
      end else if (pick_prev) begin
        res_s_r  <= prev_r[C_TIME-1:C_SURV];
        res_v_r  <= prev_r[C_SURV-1:C_VAR];
        res_ar_r <= prev_r[CNT_W-1:0];
      end else begin
        res_s_r  <= rdc_r[C_TIME-1:C_SURV];
        res_v_r  <= rdc_r[C_SURV-1:C_VAR];
        res_ar_r <= rdc_r[CNT_W-1:0];
      end
    end
    if (cmd.q_emit) begin
      out_time_r <= DATA_W'(qt_r);
      out_surv_r <= res_s_r;
      out_var_r  <= res_v_r;
      out_ar_r   <= res_ar_r;
      out_last_r <= 1'b1;
      out_ovf_r  <= ovf_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_time_value = out_time_r;
  assign out_survival   = out_surv_r;
  assign out_var_hazard = out_var_r;
  assign out_at_risk    = out_ar_r;
  assign out_last       = out_last_r;
  assign out_overflow   = out_ovf_r;

endmodule

[src/kaplan_meier_curve_engine_unit.sv]
// product-limit survival engine with left truncation and greenwood variance.
// op load stores one sample (time, event flag, entry time) per request;
// samples past capacity are dropped and the overflow flag rises until a
// clear. op compute walks the stored samples: each sample is fetched and
// tied times are merged, then for each distinct time a counting pass runs
// over the sample store, and where the estimate steps, two serial divisions
// follow (one quotient bit a cycle over 39 bits, then the done flag) before
// the point is written. one result is sent per distinct time, the final one
// marked by last. op query scans the stored curve through its single read
// port. requests are taken only while the sequencer is idle; a finished
// result sits in the output register so the next request may be taken before
// it leaves. reverse mode swaps events for losses; the left-step setting picks
// the left-continuous step. no clearing pass after reset is needed.
module kaplan_meier_curve_engine_unit #(
  parameter int MAX_SAMPLES = 64,
  parameter int TIME_BITS   = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  kmce_in_if.sink                         in_ch,
  kmce_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [kmce_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [kmce_pkg::CFG_DATA_W-1:0] cfg_data
);
  import kmce_pkg::*;

  kmce_cmd_t cmd;
  kmce_sts_t sts;

  // sequencer: one state per step of load, curve build and query
  kmce_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_op    (in_ch.op),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // sample and curve stores, counters, divider and output register
  kmce_dp #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .TIME_BITS   (TIME_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .cfg_we         (cfg_we),
    .cfg_idx        (cfg_idx),
    .cfg_data       (cfg_data),
    .in_sample_time (in_ch.sample_time),
    .in_event_flag  (in_ch.event_flag),
    .in_entry_time  (in_ch.entry_time),
    .in_query_time  (in_ch.query_time),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_time_value (out_ch.time_value),
    .out_survival   (out_ch.survival),
    .out_var_hazard (out_ch.var_hazard),
    .out_at_risk    (out_ch.at_risk),
    .out_last       (out_ch.last),
    .out_overflow   (out_ch.overflow)
  );

endmodule

[src/kmce_chk.sv]
module kmce_chk (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [kmce_pkg::DATA_W-1:0] survival,
  input logic [kmce_pkg::CNT_W-1:0]  at_risk
);
  import kmce_pkg::*;

  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_out_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_surv_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> survival <= Q31_ONE)
    else $error("survival above one");

  a_risk_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> at_risk <= CNT_W'(64))
    else $error("at-risk count above capacity");

endmodule

bind kaplan_meier_curve_engine_unit kmce_chk u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .survival  (out_ch.survival),
  .at_risk   (out_ch.at_risk)
);
